>>> hw/rtl/link_reconnect_backoff_controller_top_defines.svh
// ----------------------------------------------------------------------------
// Link reconnect backoff controller: assertion macros
// Shared forms for the port-level checks; expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LINK_RECONNECT_BACKOFF_CONTROLLER_TOP_DEFINES_SVH
`define LINK_RECONNECT_BACKOFF_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define LRBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrbc check failed");

// next-cycle implication
`define LRBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrbc check failed");

`endif

>>> hw/rtl/lrbc_pkg.sv
// ----------------------------------------------------------------------------
// lrbc_pkg
// Codes, configuration types and the reason classifier of the link reconnect
// backoff controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lrbc_pkg;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // action codes
    localparam logic [2:0] ACT_TICK       = 3'd0;
    localparam logic [2:0] ACT_CONNECT    = 3'd1;
    localparam logic [2:0] ACT_STOP       = 3'd2;
    localparam logic [2:0] ACT_DISCONNECT = 3'd3;
    localparam logic [2:0] ACT_GOT_ADDR   = 3'd4;

    // event codes
    localparam logic [1:0] EV_NONE       = 2'd0;
    localparam logic [1:0] EV_CONNECTING = 2'd1;
    localparam logic [1:0] EV_CONNECTED  = 2'd2;
    localparam logic [1:0] EV_FAILED     = 2'd3;

    // status codes
    localparam logic [2:0] ST_IDLE         = 3'd0;
    localparam logic [2:0] ST_CONNECTING   = 3'd1;
    localparam logic [2:0] ST_CONNECTED    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd3;
    localparam logic [2:0] ST_AUTH_ERROR   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT      = 3'd5;
    localparam logic [2:0] ST_DISCONNECTED = 3'd6;

    // radio commands
    localparam logic [1:0] CMD_NONE       = 2'd0;
    localparam logic [1:0] CMD_CONNECT    = 2'd1;
    localparam logic [1:0] CMD_DISCONNECT = 2'd2;

    // disconnect reason codes
    localparam logic [7:0] RSN_AUTH_EXPIRE   = 8'd2;
    localparam logic [7:0] RSN_MIC_FAILURE   = 8'd14;
    localparam logic [7:0] RSN_4WAY_TIMEOUT  = 8'd15;
    localparam logic [7:0] RSN_BEACON_LOST   = 8'd200;
    localparam logic [7:0] RSN_NO_AP         = 8'd201;
    localparam logic [7:0] RSN_AUTH_FAIL     = 8'd202;
    localparam logic [7:0] RSN_HANDSHAKE_TMO = 8'd204;
    localparam logic [7:0] RSN_CONN_FAIL     = 8'd205;

    // configuration register indexes
    localparam logic [2:0] CFG_MAX_RETRIES = 3'd0;
    localparam logic [2:0] CFG_CONN_TMO    = 3'd1;
    localparam logic [2:0] CFG_BACKOFF_BASE = 3'd2;
    localparam logic [2:0] CFG_BACKOFF_MULT = 3'd3;
    localparam logic [2:0] CFG_BACKOFF_MAX = 3'd4;
    localparam logic [2:0] CFG_FAST_FAIL   = 3'd5;

    // configuration reset values
    localparam logic [7:0]  RST_MAX_RETRIES  = 8'd5;
    localparam logic [23:0] RST_CONN_TMO     = 24'd15000;
    localparam logic [23:0] RST_BACKOFF_BASE = 24'd1000;
    localparam logic [4:0]  RST_BACKOFF_MULT = 5'd2;
    localparam logic [23:0] RST_BACKOFF_MAX  = 24'd30000;
    localparam logic        RST_FAST_FAIL    = 1'b1;

    typedef struct packed {
        logic [7:0]  retry_limit;
        logic [23:0] attempt_ticks;
        logic [23:0] delay_base;
        logic [4:0]  delay_factor;
        logic [23:0] delay_cap;
        logic        fast_fail_on_auth;
    } cfg_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] status;
        logic [7:0] fail_reason;
        logic [1:0] radio_cmd;
        logic [7:0] retry_count;
    } res_t;

    function automatic logic [2:0] classify(input logic [7:0] reason);
        logic [2:0] st;
        unique case (reason) inside
            RSN_NO_AP:
                st = ST_NOT_FOUND;
            RSN_AUTH_FAIL, RSN_AUTH_EXPIRE, RSN_4WAY_TIMEOUT, RSN_HANDSHAKE_TMO,
            RSN_MIC_FAILURE:
                st = ST_AUTH_ERROR;
            RSN_CONN_FAIL, RSN_BEACON_LOST:
                st = ST_TIMEOUT;
            default:
                st = ST_DISCONNECTED;
        endcase
        return st;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lrbc_core.sv
// ----------------------------------------------------------------------------
// lrbc_core
// Connection state, timers and backoff; computes one result per step and
// commits the state update when the step is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbc_core #(
    parameter int TIME_BITS = 24
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic [2:0]     action,
    input  wire logic [7:0]     reason,
    input  wire lrbc_pkg::cfg_t cfg,
    output lrbc_pkg::res_t      res_next
);

    localparam int WB = ((TIME_BITS > 24) ? TIME_BITS : 24) + 5;
    localparam logic [WB-1:0] TMAX_W = {{(WB-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
    localparam logic [TIME_BITS-1:0] BASE_RST =
        (WB'(lrbc_pkg::RST_BACKOFF_BASE) > TMAX_W) ? TMAX_W[TIME_BITS-1:0]
                                                    : TIME_BITS'(lrbc_pkg::RST_BACKOFF_BASE);

    function automatic logic [TIME_BITS-1:0] sat_time(input logic [WB-1:0] v);
        logic [TIME_BITS-1:0] r;
        r = (v > TMAX_W) ? TMAX_W[TIME_BITS-1:0] : v[TIME_BITS-1:0];
        return r;
    endfunction

    logic                 active_reg,      active_next;
    logic                 link_up_reg,     link_up_next;
    logic                 timed_out_reg,   timed_out_next;
    logic [7:0]           retries_reg,     retries_next;
    logic [TIME_BITS-1:0] delay_reg,       delay_next;
    logic [TIME_BITS-1:0] retry_cd_reg,    retry_cd_next;
    logic                 retry_armed_reg, retry_armed_next;
    logic [TIME_BITS-1:0] att_cd_reg,      att_cd_next;
    logic                 att_armed_reg,   att_armed_next;
    logic [2:0]           status_reg,      status_next;

    logic [TIME_BITS-1:0] base_sat;
    logic [TIME_BITS-1:0] tmo_sat;
    logic [TIME_BITS-1:0] delay_src;
    logic [WB-1:0]        prod;
    logic [WB-1:0]        capped;
    logic [TIME_BITS-1:0] delay_grown;
    logic [2:0]           cls;
    logic [2:0]           st;
    logic [7:0]           retries_inc;
    logic                 att_fire;
    logic                 ret_fire;
    logic [1:0]           ev;
    logic [1:0]           cmd;
    logic [7:0]           fr;

    assign base_sat    = sat_time(WB'(cfg.delay_base));
    assign tmo_sat     = sat_time(WB'(cfg.attempt_ticks));
    assign delay_src   = link_up_reg ? base_sat : delay_reg;
    assign prod        = WB'(delay_src) * WB'(cfg.delay_factor);
    assign capped      = (prod > WB'(cfg.delay_cap)) ? WB'(cfg.delay_cap) : prod;
    assign delay_grown = sat_time(capped);
    assign cls         = lrbc_pkg::classify(reason);
    assign st          = timed_out_reg ? lrbc_pkg::ST_TIMEOUT : cls;
    assign retries_inc = (retries_reg == 8'hFF) ? retries_reg : retries_reg + 8'd1;
    assign att_fire    = att_armed_reg && (att_cd_reg <= TIME_BITS'(1));
    assign ret_fire    = retry_armed_reg && (retry_cd_reg <= TIME_BITS'(1));

    always_comb
    begin
        active_next      = active_reg;
        link_up_next     = link_up_reg;
        timed_out_next   = timed_out_reg;
        retries_next     = retries_reg;
        delay_next       = delay_reg;
        retry_cd_next    = retry_cd_reg;
        retry_armed_next = retry_armed_reg;
        att_cd_next      = att_cd_reg;
        att_armed_next   = att_armed_reg;
        status_next      = status_reg;
        ev               = lrbc_pkg::EV_NONE;
        cmd              = lrbc_pkg::CMD_NONE;
        fr               = 8'd0;

        case (action)
            lrbc_pkg::ACT_TICK:
            begin
                if (att_armed_reg)
                begin
                    if (att_fire)
                        att_armed_next = 1'b0;
                    else
                        att_cd_next = att_cd_reg - TIME_BITS'(1);
                end
                if (retry_armed_reg)
                begin
                    if (ret_fire)
                        retry_armed_next = 1'b0;
                    else
                        retry_cd_next = retry_cd_reg - TIME_BITS'(1);
                end
                if (ret_fire)
                begin
                    if (active_reg && !link_up_reg)
                    begin
                        timed_out_next = 1'b0;
                        status_next    = lrbc_pkg::ST_CONNECTING;
                        ev             = lrbc_pkg::EV_CONNECTING;
                        att_cd_next    = tmo_sat;
                        att_armed_next = 1'b1;
                        cmd            = lrbc_pkg::CMD_CONNECT;
                    end
                end
                else if (att_fire && active_reg && !link_up_reg)
                begin
                    timed_out_next = 1'b1;
                    cmd            = lrbc_pkg::CMD_DISCONNECT;
                end
            end
            lrbc_pkg::ACT_CONNECT:
            begin
                active_next    = 1'b1;
                link_up_next   = 1'b0;
                retries_next   = 8'd0;
                delay_next     = base_sat;
                timed_out_next = 1'b0;
                status_next    = lrbc_pkg::ST_CONNECTING;
                ev             = lrbc_pkg::EV_CONNECTING;
                att_cd_next    = tmo_sat;
                att_armed_next = 1'b1;
                cmd            = lrbc_pkg::CMD_CONNECT;
            end
            lrbc_pkg::ACT_STOP:
            begin
                active_next      = 1'b0;
                link_up_next     = 1'b0;
                retry_armed_next = 1'b0;
                att_armed_next   = 1'b0;
                cmd              = lrbc_pkg::CMD_DISCONNECT;
                status_next      = lrbc_pkg::ST_IDLE;
            end
            lrbc_pkg::ACT_DISCONNECT:
            begin
                att_armed_next = 1'b0;
                if (active_reg)
                begin
                    if (link_up_reg)
                    begin
                        link_up_next     = 1'b0;
                        retries_next     = 8'd0;
                        status_next      = st;
                        retry_cd_next    = delay_src;
                        retry_armed_next = 1'b1;
                        delay_next       = delay_grown;
                    end
                    else if (cfg.fast_fail_on_auth && !timed_out_reg &&
                             (cls == lrbc_pkg::ST_AUTH_ERROR))
                    begin
                        active_next      = 1'b0;
                        retry_armed_next = 1'b0;
                        status_next      = lrbc_pkg::ST_AUTH_ERROR;
                        ev               = lrbc_pkg::EV_FAILED;
                        fr               = reason;
                    end
                    else
                    begin
                        retries_next = retries_inc;
                        if (retries_inc >= cfg.retry_limit)
                        begin
                            active_next      = 1'b0;
                            retry_armed_next = 1'b0;
                            status_next      = st;
                            ev               = lrbc_pkg::EV_FAILED;
                            fr               = reason;
                        end
                        else
                        begin
                            status_next      = st;
                            retry_cd_next    = delay_src;
                            retry_armed_next = 1'b1;
                            delay_next       = delay_grown;
                        end
                    end
                end
            end
            lrbc_pkg::ACT_GOT_ADDR:
            begin
                att_armed_next   = 1'b0;
                retry_armed_next = 1'b0;
                link_up_next     = 1'b1;
                retries_next     = 8'd0;
                delay_next       = base_sat;
                status_next      = lrbc_pkg::ST_CONNECTED;
                ev               = lrbc_pkg::EV_CONNECTED;
            end
            default:
            begin
            end
        endcase

        res_next.event_res   = ev;
        res_next.status      = status_next;
        res_next.fail_reason = fr;
        res_next.radio_cmd   = cmd;
        res_next.retry_count = retries_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            link_up_reg     <= 1'b0;
            timed_out_reg   <= 1'b0;
            retries_reg     <= 8'd0;
            delay_reg       <= BASE_RST;
            retry_cd_reg    <= '0;
            retry_armed_reg <= 1'b0;
            att_cd_reg      <= '0;
            att_armed_reg   <= 1'b0;
            status_reg      <= lrbc_pkg::ST_IDLE;
        end
        else if (step)
        begin
            active_reg      <= active_next;
            link_up_reg     <= link_up_next;
            timed_out_reg   <= timed_out_next;
            retries_reg     <= retries_next;
            delay_reg       <= delay_next;
            retry_cd_reg    <= retry_cd_next;
            retry_armed_reg <= retry_armed_next;
            att_cd_reg      <= att_cd_next;
            att_armed_reg   <= att_armed_next;
            status_reg      <= status_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/link_reconnect_backoff_controller_top.sv
// ----------------------------------------------------------------------------
// link_reconnect_backoff_controller_top
// Reconnect controller with capped exponential backoff and retry limit.
// ----------------------------------------------------------------------------
// Takes one event per clock while in_ready is high (tick, connect, stop,
// disconnect with reason, got address) and returns exactly one result for
// each. An event is latched in an input register, evaluated combinationally
// against the controller state, and its result is held in an output register
// that raises out_valid; sustained throughput is one event per cycle while
// out_ready stays high. in_ready drops only when both the input and output
// registers hold beats that the consumer has not taken.
// Configuration writes are always ready and take effect on the next event.
`default_nettype none

module link_reconnect_backoff_controller_top #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    action,
    input  wire logic [7:0]                    reason,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         event_res,
    output logic [2:0]                         status,
    output logic [7:0]                         fail_reason,
    output logic [1:0]                         radio_cmd,
    output logic [7:0]                         retry_count,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lrbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lrbc_pkg::CFG_DATA_W-1:0] cfg_data
);

    lrbc_pkg::cfg_t cfg_reg;
    lrbc_pkg::res_t res_reg;
    lrbc_pkg::res_t res_next;

    logic       in_vld_reg;
    logic [2:0] action_reg;
    logic [7:0] reason_reg;
    logic       out_vld_reg;
    logic       advance;

    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit       <= lrbc_pkg::RST_MAX_RETRIES;
            cfg_reg.attempt_ticks     <= lrbc_pkg::RST_CONN_TMO;
            cfg_reg.delay_base        <= lrbc_pkg::RST_BACKOFF_BASE;
            cfg_reg.delay_factor      <= lrbc_pkg::RST_BACKOFF_MULT;
            cfg_reg.delay_cap         <= lrbc_pkg::RST_BACKOFF_MAX;
            cfg_reg.fast_fail_on_auth <= lrbc_pkg::RST_FAST_FAIL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lrbc_pkg::CFG_MAX_RETRIES:  cfg_reg.retry_limit       <= cfg_data[7:0];
                lrbc_pkg::CFG_CONN_TMO:     cfg_reg.attempt_ticks     <= cfg_data;
                lrbc_pkg::CFG_BACKOFF_BASE: cfg_reg.delay_base        <= cfg_data;
                lrbc_pkg::CFG_BACKOFF_MULT: cfg_reg.delay_factor      <= cfg_data[4:0];
                lrbc_pkg::CFG_BACKOFF_MAX:  cfg_reg.delay_cap         <= cfg_data;
                lrbc_pkg::CFG_FAST_FAIL:    cfg_reg.fast_fail_on_auth <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            reason_reg <= reason;
        end
    end

    lrbc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .action   (action_reg),
        .reason   (reason_reg),
        .cfg      (cfg_reg),
        .res_next (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid   = out_vld_reg;
    assign event_res   = res_reg.event_res;
    assign status      = res_reg.status;
    assign fail_reason = res_reg.fail_reason;
    assign radio_cmd   = res_reg.radio_cmd;
    assign retry_count = res_reg.retry_count;

endmodule

`default_nettype wire

>>> hw/rtl/lrbc_checker.sv
// ----------------------------------------------------------------------------
// lrbc_checker
// Port-level checks of the reconnect controller results, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "link_reconnect_backoff_controller_top_defines.svh"

module lrbc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] event_res,
    input wire logic [2:0] status,
    input wire logic [7:0] fail_reason,
    input wire logic [1:0] radio_cmd,
    input wire logic [7:0] retry_count
);

    `LRBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(status) && $stable(fail_reason) && $stable(radio_cmd) && $stable(retry_count))
    `LRBC_ASSERT_NOW(a_reason_only_on_fail, out_valid && (event_res != lrbc_pkg::EV_FAILED), fail_reason == 8'd0)
    `LRBC_ASSERT_NOW(a_connect_cmd, out_valid && (radio_cmd == lrbc_pkg::CMD_CONNECT), (event_res == lrbc_pkg::EV_CONNECTING) && (status == lrbc_pkg::ST_CONNECTING))
    `LRBC_ASSERT_NOW(a_connected, out_valid && (event_res == lrbc_pkg::EV_CONNECTED), (status == lrbc_pkg::ST_CONNECTED) && (retry_count == 8'd0) && (radio_cmd == lrbc_pkg::CMD_NONE))
    `LRBC_ASSERT_NOW(a_fail_status, out_valid && (event_res == lrbc_pkg::EV_FAILED), (status == lrbc_pkg::ST_NOT_FOUND) || (status == lrbc_pkg::ST_AUTH_ERROR) || (status == lrbc_pkg::ST_TIMEOUT) || (status == lrbc_pkg::ST_DISCONNECTED))

endmodule

bind link_reconnect_backoff_controller_top lrbc_checker u_lrbc_checker (.*);

`default_nettype wire
